[design/bsr4x4_row_matvec_accumulator_top_assert.svh]
// Assertion macros for the block-row matrix-vector accumulator checker.
`ifndef BSR4X4_ROW_MATVEC_ACCUMULATOR_TOP_ASSERT_SVH
`define BSR4X4_ROW_MATVEC_ACCUMULATOR_TOP_ASSERT_SVH

// Same-cycle implication, off while reset is high.
`define BSRMV_ASSERT_HOLDS(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication, off while reset is high.
`define BSRMV_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

// Next-cycle implication that also runs through reset.
`define BSRMV_ASSERT_NEXT_ALWAYS(label, cond, prop, msg) \
  label: assert property (@(posedge clk) (cond) |=> (prop)) \
    else $error(msg);

`endif

[design/bsrmv_pkg.sv]
// Shared types and constants for the block-row matrix-vector accumulator.
`timescale 1ns / 1ps
package bsrmv_pkg;

  localparam int DATA_W    = 32;
  localparam int ACC_W     = 48;
  localparam int LANES     = 4;
  localparam int LANE_W    = 2;
  localparam int JOB_DEPTH = 2;
  localparam int OUT_DEPTH = 8;

  localparam logic [1:0] CMD_ADD       = 2'd0;
  localparam logic [1:0] CMD_ADD_CLOSE = 2'd1;
  localparam logic [1:0] CMD_CLOSE     = 2'd2;
  localparam logic [1:0] CMD_NONE      = 2'd3;

  localparam logic [1:0] REG_ALPHA        = 2'd0;
  localparam logic [1:0] REG_BETA         = 2'd1;
  localparam logic [1:0] REG_COLUMN_MAJOR = 2'd2;

  localparam logic [LANE_W-1:0] LANE_LAST = 2'd3;

  typedef struct packed {
    logic [1:0]               cmd;
    logic [3:0]               element_pos;
    logic signed [DATA_W-1:0] matrix_value;
    logic signed [DATA_W-1:0] x_value;
    logic signed [DATA_W-1:0] old_y0;
    logic signed [DATA_W-1:0] old_y1;
    logic signed [DATA_W-1:0] old_y2;
    logic signed [DATA_W-1:0] old_y3;
  } in_beat_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] y_value;
    logic [LANE_W-1:0]        lane;
    logic                     last;
  } out_beat_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] alpha_gain;
    logic signed [DATA_W-1:0] beta_gain;
    logic                     column_major;
  } cfg_t;

  typedef struct packed {
    logic [LANES-1:0][ACC_W-1:0]  sums;
    logic [LANES-1:0][DATA_W-1:0] olds;
  } close_job_t;

endpackage

[design/bsr4x4_row_matvec_accumulator_top.sv]
// Top level of the 4x4 block-row sparse matrix-vector accumulator.
//
//   channel   direction  handshake               beat
//   item      in         push / full             in_beat_t
//   result    out        empty / pop             out_beat_t
//   config    in         cfg_we (no wait)        cfg_index, cfg_data
//
// An element beat is taken every cycle unless full is raised; the accumulator
// update is made from the registered beat. A row close yields four result
// beats, one per cycle while the result queue has room, from a scaling
// pipeline. Closes arriving faster than the back end drains them back up
// into the job queue and then raise full. Reset clears the accumulators and
// the queues, sets the alpha gain to one and clears the beta gain.
`timescale 1ns / 1ps
module bsr4x4_row_matvec_accumulator_top import bsrmv_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  in_beat_t          item,
  output logic              empty,
  input  logic              pop,
  output out_beat_t         result,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [DATA_W-1:0] cfg_data
);

  localparam logic signed [DATA_W-1:0] ONE_Q = DATA_W'(1) << FRAC_BITS;

  cfg_t       cfg;
  logic       job_push;
  close_job_t job_in;
  logic       job_room;
  logic       job_valid;
  close_job_t job_out;
  logic       job_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.alpha_gain   <= ONE_Q;
      cfg.beta_gain    <= '0;
      cfg.column_major <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ALPHA:        cfg.alpha_gain   <= cfg_data;
        REG_BETA:         cfg.beta_gain    <= cfg_data;
        REG_COLUMN_MAJOR: cfg.column_major <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  bsrmv_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .column_major (cfg.column_major),
    .push         (push),
    .full         (full),
    .item         (item),
    .job_push     (job_push),
    .job          (job_in),
    .job_room     (job_room)
  );

  bsrmv_job_queue u_job_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (job_push),
    .wr_job   (job_in),
    .room     (job_room),
    .rd_valid (job_valid),
    .rd_job   (job_out),
    .rd_take  (job_take)
  );

  bsrmv_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .job_valid (job_valid),
    .job       (job_out),
    .job_take  (job_take),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

[design/bsrmv_front.sv]
// Front end: takes input beats, forms products and keeps the row accumulators.
`timescale 1ns / 1ps
module bsrmv_front import bsrmv_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       column_major,
  input  logic       push,
  output logic       full,
  input  in_beat_t   item,
  output logic       job_push,
  output close_job_t job,
  input  logic       job_room
);

  localparam int PROD_W = 2 * DATA_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam logic signed [SUM_W-1:0] ACC_MAX =
    {{(SUM_W-ACC_W+1){1'b0}}, {(ACC_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] ACC_MIN =
    {{(SUM_W-ACC_W+1){1'b1}}, {(ACC_W-1){1'b0}}};

  logic                         s1_valid;
  logic [1:0]                   s1_cmd;
  logic [LANE_W-1:0]            s1_row;
  logic signed [PROD_W-1:0]     s1_prod;
  logic [LANES-1:0][DATA_W-1:0] s1_old;
  logic signed [ACC_W-1:0]      acc [LANES];

  logic signed [PROD_W-1:0]     mul;
  logic signed [PROD_W-1:0]     prod_sh;
  logic signed [ACC_W-1:0]      acc_sel;
  logic signed [SUM_W-1:0]      sum_wide;
  logic signed [ACC_W-1:0]      acc_sat;
  logic [LANES-1:0][ACC_W-1:0]  new_sum;
  logic                         has_add;
  logic                         closes;
  logic                         stall;
  logic                         advance;

  assign mul     = item.matrix_value * item.x_value;
  assign prod_sh = s1_prod >>> FRAC_BITS;
  assign has_add = (s1_cmd == CMD_ADD) || (s1_cmd == CMD_ADD_CLOSE);
  assign closes  = (s1_cmd == CMD_ADD_CLOSE) || (s1_cmd == CMD_CLOSE);
  assign stall   = s1_valid && closes && !job_room;
  assign advance = s1_valid && !stall;
  assign full    = stall;

  assign acc_sel  = acc[s1_row];
  assign sum_wide = $signed({{(SUM_W-ACC_W){acc_sel[ACC_W-1]}}, acc_sel})
                  + $signed({prod_sh[PROD_W-1], prod_sh});

  always_comb begin
    if (sum_wide > ACC_MAX) begin
      acc_sat = {1'b0, {(ACC_W-1){1'b1}}};
    end else if (sum_wide < ACC_MIN) begin
      acc_sat = {1'b1, {(ACC_W-1){1'b0}}};
    end else begin
      acc_sat = sum_wide[ACC_W-1:0];
    end
    for (int r = 0; r < LANES; r++) begin
      new_sum[r] = (has_add && (s1_row == LANE_W'(r))) ? acc_sat : acc[r];
    end
  end

  assign job_push = advance && closes;
  assign job.sums = new_sum;
  assign job.olds = s1_old;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      for (int r = 0; r < LANES; r++) begin
        acc[r] <= '0;
      end
    end else begin
      if (!stall) begin
        s1_valid <= push && (item.cmd != CMD_NONE);
      end
      if (advance) begin
        for (int r = 0; r < LANES; r++) begin
          acc[r] <= closes ? '0 : new_sum[r];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      s1_cmd  <= item.cmd;
      s1_row  <= column_major ? item.element_pos[1:0] : item.element_pos[3:2];
      s1_prod <= mul;
      s1_old  <= {item.old_y3, item.old_y2, item.old_y1, item.old_y0};
    end
  end

endmodule

[design/bsrmv_job_queue.sv]
// Short queue of row-close jobs between the front and back ends.
`timescale 1ns / 1ps
module bsrmv_job_queue import bsrmv_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       wr_valid,
  input  close_job_t wr_job,
  output logic       room,
  output logic       rd_valid,
  output close_job_t rd_job,
  input  logic       rd_take
);

  localparam int PTR_W = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;
  localparam int CNT_W = $clog2(JOB_DEPTH + 1);

  close_job_t       slots [JOB_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign room     = count < CNT_W'(JOB_DEPTH);
  assign rd_valid = count != '0;
  assign rd_job   = slots[rd_ptr];
  assign do_wr    = wr_valid && room;
  assign do_rd    = rd_take && rd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(JOB_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(JOB_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(do_wr) - CNT_W'(do_rd);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_job;
    end
  end

endmodule

[design/bsrmv_back.sv]
// Back end: scales each lane of a closed row and queues the results.
`timescale 1ns / 1ps
module bsrmv_back import bsrmv_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       job_valid,
  input  close_job_t job,
  output logic       job_take,
  output logic       empty,
  input  logic       pop,
  output out_beat_t  result
);

  localparam int SPLIT    = 24;
  localparam int HI_W     = ACC_W - SPLIT;
  localparam int PHI_W    = DATA_W + HI_W;
  localparam int PLO_W    = DATA_W + SPLIT + 1;
  localparam int POLD_W   = 2 * DATA_W;
  localparam int REST_W   = POLD_W + 1;
  localparam int HI_SHIFT = SPLIT - FRAC_BITS;
  localparam int RW       = REST_W + 1 + HI_SHIFT;
  localparam int PTR_W    = $clog2(OUT_DEPTH);
  localparam int CNT_W    = $clog2(OUT_DEPTH + 1);
  localparam logic signed [RW-1:0] Y_MAX = {{(RW-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
  localparam logic signed [RW-1:0] Y_MIN = {{(RW-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};

  logic [LANE_W-1:0]        lane_cnt;
  logic                     issue;
  logic [ACC_W-1:0]         sum_sel;
  logic signed [HI_W-1:0]   hi_part;
  logic signed [SPLIT:0]    lo_part;
  logic signed [DATA_W-1:0] old_sel;
  logic signed [PHI_W-1:0]  p_hi_c;
  logic signed [PLO_W-1:0]  p_lo_c;
  logic signed [POLD_W-1:0] p_old_c;

  logic                     v1;
  logic [LANE_W-1:0]        l1;
  logic signed [PHI_W-1:0]  p_hi;
  logic signed [PLO_W-1:0]  p_lo;
  logic signed [POLD_W-1:0] p_old;

  logic                     v2;
  logic [LANE_W-1:0]        l2;
  logic signed [PHI_W-1:0]  hi2;
  logic signed [REST_W-1:0] rest2;
  logic signed [REST_W-1:0] rest_c;

  logic signed [RW-1:0]     hi_term;
  logic signed [RW-1:0]     rest_term;
  logic signed [RW-1:0]     total;
  logic signed [DATA_W-1:0] y_sat;
  out_beat_t                wr_beat;

  out_beat_t                fifo [OUT_DEPTH];
  logic [PTR_W-1:0]         wr_ptr;
  logic [PTR_W-1:0]         rd_ptr;
  logic [CNT_W-1:0]         out_count;
  logic [CNT_W:0]           reserved;
  logic                     do_rd;

  // Space is reserved for beats still in the scaling pipeline.
  assign reserved = {1'b0, out_count} + (CNT_W + 1)'(v1) + (CNT_W + 1)'(v2);
  assign issue    = job_valid && (reserved < (CNT_W + 1)'(OUT_DEPTH));
  assign job_take = issue && (lane_cnt == LANE_LAST);

  assign sum_sel = job.sums[lane_cnt];
  assign hi_part = sum_sel[ACC_W-1:SPLIT];
  assign lo_part = $signed({1'b0, sum_sel[SPLIT-1:0]});
  assign old_sel = job.olds[lane_cnt];
  assign p_hi_c  = cfg.alpha_gain * hi_part;
  assign p_lo_c  = cfg.alpha_gain * lo_part;
  assign p_old_c = cfg.beta_gain * old_sel;

  assign rest_c = $signed({{(REST_W-PLO_W){p_lo[PLO_W-1]}}, p_lo})
                + $signed({p_old[POLD_W-1], p_old});

  // alpha*sum + beta*old, floored once by the fraction width.
  assign hi_term   = $signed({{(RW-PHI_W){hi2[PHI_W-1]}}, hi2}) <<< HI_SHIFT;
  assign rest_term = $signed({{(RW-REST_W){rest2[REST_W-1]}}, rest2}) >>> FRAC_BITS;
  assign total     = hi_term + rest_term;

  always_comb begin
    if (total > Y_MAX) begin
      y_sat = {1'b0, {(DATA_W-1){1'b1}}};
    end else if (total < Y_MIN) begin
      y_sat = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      y_sat = total[DATA_W-1:0];
    end
    wr_beat.y_value = y_sat;
    wr_beat.lane    = l2;
    wr_beat.last    = l2 == LANE_LAST;
  end

  assign empty  = out_count == '0;
  assign result = fifo[rd_ptr];
  assign do_rd  = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      lane_cnt  <= '0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      out_count <= '0;
    end else begin
      if (issue) begin
        lane_cnt <= lane_cnt + 1'b1;
      end
      v1 <= issue;
      v2 <= v1;
      if (v2) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      out_count <= out_count + CNT_W'(v2) - CNT_W'(do_rd);
    end
  end

  always_ff @(posedge clk) begin
    l1    <= lane_cnt;
    p_hi  <= p_hi_c;
    p_lo  <= p_lo_c;
    p_old <= p_old_c;
    l2    <= l1;
    hi2   <= p_hi;
    rest2 <= rest_c;
    if (v2) begin
      fifo[wr_ptr] <= wr_beat;
    end
  end

endmodule

[design/bsrmv_checker.sv]
// Port-level checker for the block-row accumulator, bound to the top level.
`timescale 1ns / 1ps
`include "bsr4x4_row_matvec_accumulator_top_assert.svh"
module bsrmv_checker import bsrmv_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      empty,
  input logic      pop,
  input out_beat_t result
);

  logic [LANE_W-1:0] exp_lane;

  always_ff @(posedge clk) begin
    if (rst) begin
      exp_lane <= '0;
    end else if (pop && !empty) begin
      exp_lane <= exp_lane + 1'b1;
    end
  end

  `BSRMV_ASSERT_HOLDS(a_lane_order, !empty, result.lane == exp_lane, "result lane out of order")
  `BSRMV_ASSERT_HOLDS(a_last_flag, !empty, result.last == (result.lane == LANE_LAST), "last flag wrong")
  `BSRMV_ASSERT_NEXT(a_result_held, !empty && !pop, !empty && $stable(result), "unpopped beat changed")
  `BSRMV_ASSERT_NEXT_ALWAYS(a_reset_empty, rst, empty, "results present after reset")

endmodule

bind bsr4x4_row_matvec_accumulator_top bsrmv_checker u_checker (
  .clk    (clk),
  .rst    (rst),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);
